>>> src/toaf_pkg.sv
// Shared types, constants and the control store of the third-order altitude filter.
package toaf_pkg;

    localparam int ACCUM_W   = 48;
    localparam int HALF_W    = (ACCUM_W + 1) / 2;
    localparam int HI_W      = ACCUM_W - HALF_W;
    localparam int DATA_W    = 32;
    localparam int DT_W      = 16;
    localparam int COEF_W    = 32;
    localparam int PROD_W    = ACCUM_W + COEF_W;
    localparam int CFG_IDX_W = 4;
    localparam int PC_W      = 5;

    // One g in Q16.16.
    localparam int ONE_G = 642689;

    typedef logic signed [ACCUM_W-1:0] acc_t;

    localparam acc_t ACC_MAX   = {1'b0, {(ACCUM_W-1){1'b1}}};
    localparam acc_t ACC_MIN   = {1'b1, {(ACCUM_W-1){1'b0}}};
    localparam acc_t NEG_ONE_G = acc_t'(-ONE_G);
    localparam acc_t OUT_MAX   = acc_t'(32'sh7FFF_FFFF);
    localparam acc_t OUT_MIN   = acc_t'(32'sh8000_0000);

    localparam logic [COEF_W-1:0] GAIN_ALT_RST  = 32'd50331648;
    localparam logic [COEF_W-1:0] GAIN_VEL_RST  = 32'd50331648;
    localparam logic [COEF_W-1:0] GAIN_BIAS_RST = 32'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_ALT  = 4'd0,
        CFG_GAIN_VEL  = 4'd1,
        CFG_GAIN_BIAS = 4'd2,
        CFG_REF_ALT   = 4'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        UOP_NOP, UOP_MUL, UOP_ADD, UOP_SUB, UOP_MOVK, UOP_CLEAR, UOP_OUT
    } uop_t;

    typedef enum logic [1:0] {
        BR_NONE, BR_CLEAR, BR_ALWAYS
    } branch_t;

    typedef enum logic [3:0] {
        SRC_ZERO, SRC_ALT, SRC_VEL, SRC_BIAS, SRC_CSUM, SRC_PPOS, SRC_ACC, SRC_ERR,
        SRC_TMP, SRC_MUL, SRC_DT, SRC_ACCEL_DOWN, SRC_BARO, SRC_REF, SRC_NEG_G
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_ALT, DST_VEL, DST_BIAS, DST_CSUM, DST_PPOS, DST_ACC, DST_ERR,
        DST_TMP, DST_KDT1, DST_KDT2, DST_KDT3
    } dst_t;

    typedef enum logic [2:0] {
        BSEL_KDT1, BSEL_KDT2, BSEL_KDT3, BSEL_DT,
        BSEL_GAIN_ALT, BSEL_GAIN_VEL, BSEL_GAIN_BIAS
    } bsel_t;

    typedef enum logic [1:0] {
        SH_16, SH_17, SH_24
    } shift_t;

    typedef struct packed {
        uop_t            op;
        branch_t         br;
        logic [PC_W-1:0] target;
        src_t            src_a;
        src_t            src_b;
        bsel_t           bsel;
        shift_t          sh;
        dst_t            dst;
        logic            set_valid;
        logic            last;
    } ucode_t;

    typedef struct packed {
        logic   load_in;
        logic   exec;
        ucode_t uw;
    } ctl_t;

    localparam logic [PC_W-1:0] PC_OUT   = PC_W'(24);
    localparam logic [PC_W-1:0] PC_CLEAR = PC_W'(25);

    function automatic ucode_t uc_base();
        ucode_t w;
        w.op        = UOP_NOP;
        w.br        = BR_NONE;
        w.target    = '0;
        w.src_a     = SRC_ZERO;
        w.src_b     = SRC_ZERO;
        w.bsel      = BSEL_DT;
        w.sh        = SH_16;
        w.dst       = DST_NONE;
        w.set_valid = 1'b0;
        w.last      = 1'b0;
        return w;
    endfunction

    function automatic ucode_t uc_mul(src_t a, bsel_t b, shift_t s);
        ucode_t w;
        w       = uc_base();
        w.op    = UOP_MUL;
        w.src_a = a;
        w.bsel  = b;
        w.sh    = s;
        return w;
    endfunction

    function automatic ucode_t uc_alu(uop_t op, src_t a, src_t b, dst_t d);
        ucode_t w;
        w       = uc_base();
        w.op    = op;
        w.src_a = a;
        w.src_b = b;
        w.dst   = d;
        return w;
    endfunction

    function automatic ucode_t uc_movk(dst_t d);
        ucode_t w;
        w     = uc_base();
        w.op  = UOP_MOVK;
        w.dst = d;
        return w;
    endfunction

    // Control store. The update program forms the three gain-time products, the
    // error, the three corrections and then the prediction over the step time.
    function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
        ucode_t w;
        w = uc_base();
        case (pc)
            PC_W'(0): begin
                w.br     = BR_CLEAR;
                w.target = PC_CLEAR;
            end
            PC_W'(1):  w = uc_mul(SRC_DT, BSEL_GAIN_ALT, SH_16);
            PC_W'(2):  w = uc_movk(DST_KDT1);
            PC_W'(3):  w = uc_mul(SRC_DT, BSEL_GAIN_VEL, SH_16);
            PC_W'(4):  w = uc_movk(DST_KDT2);
            PC_W'(5):  w = uc_mul(SRC_DT, BSEL_GAIN_BIAS, SH_16);
            PC_W'(6):  w = uc_movk(DST_KDT3);
            PC_W'(7):  w = uc_alu(UOP_SUB, SRC_NEG_G, SRC_ACCEL_DOWN, DST_ACC);
            PC_W'(8):  w = uc_alu(UOP_SUB, SRC_BARO, SRC_REF, DST_ERR);
            PC_W'(9):  w = uc_alu(UOP_SUB, SRC_ERR, SRC_ALT, DST_ERR);
            PC_W'(10): w = uc_mul(SRC_ERR, BSEL_KDT1, SH_24);
            PC_W'(11): w = uc_alu(UOP_ADD, SRC_CSUM, SRC_MUL, DST_CSUM);
            PC_W'(12): w = uc_mul(SRC_ERR, BSEL_KDT2, SH_24);
            PC_W'(13): w = uc_alu(UOP_ADD, SRC_VEL, SRC_MUL, DST_VEL);
            PC_W'(14): w = uc_mul(SRC_ERR, BSEL_KDT3, SH_24);
            PC_W'(15): w = uc_alu(UOP_ADD, SRC_BIAS, SRC_MUL, DST_BIAS);
            PC_W'(16): w = uc_alu(UOP_ADD, SRC_ACC, SRC_BIAS, DST_ACC);
            PC_W'(17): w = uc_mul(SRC_ACC, BSEL_DT, SH_17);
            PC_W'(18): w = uc_alu(UOP_ADD, SRC_VEL, SRC_MUL, DST_TMP);
            PC_W'(19): w = uc_mul(SRC_TMP, BSEL_DT, SH_16);
            PC_W'(20): w = uc_alu(UOP_ADD, SRC_PPOS, SRC_MUL, DST_PPOS);
            PC_W'(21): w = uc_alu(UOP_ADD, SRC_PPOS, SRC_CSUM, DST_ALT);
            PC_W'(22): w = uc_mul(SRC_ACC, BSEL_DT, SH_16);
            PC_W'(23): begin
                w           = uc_alu(UOP_ADD, SRC_VEL, SRC_MUL, DST_VEL);
                w.set_valid = 1'b1;
            end
            PC_OUT: begin
                w.op   = UOP_OUT;
                w.last = 1'b1;
            end
            PC_CLEAR: begin
                w.op     = UOP_CLEAR;
                w.br     = BR_ALWAYS;
                w.target = PC_OUT;
            end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

endpackage

>>> src/third_order_altitude_filter_top.sv
// Top level of the third-order complementary altitude filter.
// One transaction on the s_ channel is either an update (command 0) or a clear
// (command 1) and produces exactly one result transaction on the m_ channel. A
// clear runs only the branch, clear and output steps. An update's run time is
// set by the single shared multiplier: it makes nine passes through it, with the
// microcoded adder steps in between. The next transaction is accepted in the
// cycle after the final step. The result sits in an output register, so a new
// transaction is accepted while a result still waits; the program only stalls
// on its final step if that register is full.
// Configuration writes (gains and reference altitude) are taken every cycle.
module third_order_altitude_filter_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic signed [toaf_pkg::DATA_W-1:0] s_accel_down,
    input  logic signed [toaf_pkg::DATA_W-1:0] s_baro_altitude,
    input  logic [toaf_pkg::DT_W-1:0]          s_step_time,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [toaf_pkg::DATA_W-1:0] m_altitude_estimate,
    output logic signed [toaf_pkg::DATA_W-1:0] m_velocity_estimate,
    output logic signed [toaf_pkg::DATA_W-1:0] m_accel_up_corrected,
    output logic                               m_estimate_valid,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [toaf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [toaf_pkg::DATA_W-1:0]        cfg_data
);
    import toaf_pkg::*;

    ctl_t              ctl;
    logic              mul_start;
    logic              mul_done;
    acc_t              mul_a;
    logic [COEF_W-1:0] mul_b;
    shift_t            mul_sh;
    acc_t              mul_result;
    logic [COEF_W-1:0] mul_raw;

    assign cfg_ready = 1'b1;

    toaf_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .mul_start (mul_start),
        .mul_done  (mul_done),
        .ctl       (ctl)
    );

    toaf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .sh      (mul_sh),
        .result  (mul_result),
        .raw     (mul_raw),
        .done    (mul_done)
    );

    toaf_dp u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .ctl                  (ctl),
        .s_accel_down         (s_accel_down),
        .s_baro_altitude      (s_baro_altitude),
        .s_step_time          (s_step_time),
        .cfg_valid            (cfg_valid),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .mul_a                (mul_a),
        .mul_b                (mul_b),
        .mul_sh               (mul_sh),
        .mul_result           (mul_result),
        .mul_raw              (mul_raw),
        .m_altitude_estimate  (m_altitude_estimate),
        .m_velocity_estimate  (m_velocity_estimate),
        .m_accel_up_corrected (m_accel_up_corrected),
        .m_estimate_valid     (m_estimate_valid)
    );

endmodule

>>> src/toaf_mul.sv
// Shared multi-cycle signed-by-unsigned multiplier with truncating shift and saturation.
module toaf_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  toaf_pkg::acc_t                a,
    input  logic [toaf_pkg::COEF_W-1:0]   b,
    input  toaf_pkg::shift_t              sh,
    output toaf_pkg::acc_t                result,
    output logic [toaf_pkg::COEF_W-1:0]   raw,
    output logic                          done
);
    import toaf_pkg::*;

    typedef enum logic [2:0] {M_IDLE, M_LO, M_HI, M_SUM, M_FIN} mstate_t;

    mstate_t                    state_reg, state_next;
    logic                       done_reg, done_next;
    logic                       neg_reg;
    logic [ACCUM_W-1:0]         mag_reg, mag_next;
    logic [COEF_W-1:0]          b_reg;
    shift_t                     sh_reg;
    logic [HALF_W+COEF_W-1:0]   prod_lo_reg;
    logic [HI_W+COEF_W-1:0]     prod_hi_reg;
    logic [PROD_W-1:0]          full_reg, full_next;
    logic [PROD_W-1:0]          shifted;
    logic [PROD_W-1:0]          limit;
    logic [ACCUM_W-1:0]         mag_res;
    acc_t                       result_reg, result_next;
    logic [COEF_W-1:0]          raw_reg, raw_next;

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            M_IDLE: if (start) state_next = M_LO;
            M_LO:   state_next = M_HI;
            M_HI:   state_next = M_SUM;
            M_SUM:  state_next = M_FIN;
            M_FIN: begin
                state_next = M_IDLE;
                done_next  = 1'b1;
            end
            default: state_next = M_IDLE;
        endcase

        // Work on the magnitude so the shift truncates toward zero.
        mag_next  = a[ACCUM_W-1] ? ACCUM_W'(-a) : ACCUM_W'(a);
        full_next = {prod_hi_reg, {HALF_W{1'b0}}} + PROD_W'(prod_lo_reg);

        case (sh_reg)
            SH_16:   shifted = full_reg >> 16;
            SH_17:   shifted = full_reg >> 17;
            SH_24:   shifted = full_reg >> 24;
            default: shifted = full_reg >> 16;
        endcase

        // A negative result may reach one step further than a positive one.
        limit       = PROD_W'(ACC_MAX) + PROD_W'(neg_reg);
        mag_res     = (shifted > limit) ? limit[ACCUM_W-1:0] : shifted[ACCUM_W-1:0];
        result_next = neg_reg ? acc_t'(-mag_res) : acc_t'(mag_res);
        raw_next    = shifted[COEF_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        case (state_reg)
            M_IDLE: begin
                if (start) begin
                    neg_reg <= a[ACCUM_W-1];
                    mag_reg <= mag_next;
                    b_reg   <= b;
                    sh_reg  <= sh;
                end
            end
            M_LO:  prod_lo_reg <= mag_reg[HALF_W-1:0] * b_reg;
            M_HI:  prod_hi_reg <= mag_reg[ACCUM_W-1:HALF_W] * b_reg;
            M_SUM: full_reg <= full_next;
            M_FIN: begin
                result_reg <= result_next;
                raw_reg    <= raw_next;
            end
            default: ;
        endcase
    end

    assign result = result_reg;
    assign raw    = raw_reg;
    assign done   = done_reg;

endmodule

>>> src/toaf_seq.sv
// Microcode sequencer: step counter, control store, branching and handshakes.
module toaf_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_command,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           mul_start,
    input  logic           mul_done,
    output toaf_pkg::ctl_t ctl
);
    import toaf_pkg::*;

    typedef enum logic {ST_IDLE, ST_RUN} sstate_t;

    sstate_t         state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            issued_reg, issued_next;
    logic            cmd_reg, cmd_next;
    logic            m_valid_reg, m_valid_next;
    ucode_t          uw;
    logic            run;
    logic            in_fire;
    logic            out_full;
    logic            step_done;
    logic            take_branch;

    always_comb begin
        uw       = ucode_rom(pc_reg);
        run      = (state_reg == ST_RUN);
        in_fire  = (state_reg == ST_IDLE) && s_valid;
        out_full = m_valid_reg && !m_ready;

        case (uw.op)
            UOP_MUL: step_done = mul_done;
            UOP_OUT: step_done = !out_full;
            default: step_done = 1'b1;
        endcase

        case (uw.br)
            BR_CLEAR:  take_branch = cmd_reg;
            BR_ALWAYS: take_branch = 1'b1;
            default:   take_branch = 1'b0;
        endcase

        state_next  = state_reg;
        pc_next     = pc_reg;
        issued_next = issued_reg;
        cmd_next    = cmd_reg;

        if (in_fire) begin
            state_next  = ST_RUN;
            pc_next     = '0;
            issued_next = 1'b0;
            cmd_next    = s_command;
        end else if (run && step_done) begin
            issued_next = 1'b0;
            if (uw.last) begin
                state_next = ST_IDLE;
            end else begin
                pc_next = take_branch ? uw.target : pc_reg + PC_W'(1);
            end
        end else if (run && uw.op == UOP_MUL) begin
            issued_next = 1'b1;
        end

        mul_start = run && (uw.op == UOP_MUL) && !issued_reg;

        if (run && step_done && uw.op == UOP_OUT) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        ctl.load_in = in_fire;
        ctl.exec    = run && step_done;
        ctl.uw      = uw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

>>> src/toaf_dp.sv
// Datapath: configuration registers, filter state, saturating adder and result register.
module toaf_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  toaf_pkg::ctl_t                     ctl,
    input  logic signed [toaf_pkg::DATA_W-1:0] s_accel_down,
    input  logic signed [toaf_pkg::DATA_W-1:0] s_baro_altitude,
    input  logic [toaf_pkg::DT_W-1:0]          s_step_time,
    input  logic                               cfg_valid,
    input  logic [toaf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [toaf_pkg::DATA_W-1:0]        cfg_data,
    output toaf_pkg::acc_t                     mul_a,
    output logic [toaf_pkg::COEF_W-1:0]        mul_b,
    output toaf_pkg::shift_t                   mul_sh,
    input  toaf_pkg::acc_t                     mul_result,
    input  logic [toaf_pkg::COEF_W-1:0]        mul_raw,
    output logic signed [toaf_pkg::DATA_W-1:0] m_altitude_estimate,
    output logic signed [toaf_pkg::DATA_W-1:0] m_velocity_estimate,
    output logic signed [toaf_pkg::DATA_W-1:0] m_accel_up_corrected,
    output logic                               m_estimate_valid
);
    import toaf_pkg::*;

    logic [COEF_W-1:0]          gain_alt_reg;
    logic [COEF_W-1:0]          gain_vel_reg;
    logic [COEF_W-1:0]          gain_bias_reg;
    logic signed [DATA_W-1:0]   ref_alt_reg;

    acc_t                       alt_reg;
    acc_t                       vel_reg;
    acc_t                       bias_reg;
    acc_t                       csum_reg;
    acc_t                       ppos_reg;
    logic                       valid_reg;

    acc_t                       acc_reg;
    acc_t                       err_reg;
    acc_t                       tmp_reg;
    logic [COEF_W-1:0]          kdt1_reg;
    logic [COEF_W-1:0]          kdt2_reg;
    logic [COEF_W-1:0]          kdt3_reg;

    logic signed [DATA_W-1:0]   accel_down_reg;
    logic signed [DATA_W-1:0]   baro_reg;
    logic [DT_W-1:0]            dt_reg;

    logic signed [DATA_W-1:0]   out_alt_reg;
    logic signed [DATA_W-1:0]   out_vel_reg;
    logic signed [DATA_W-1:0]   out_acc_reg;
    logic                       out_valid_reg;

    acc_t                       opnd_a;
    acc_t                       opnd_b;
    logic signed [ACCUM_W:0]    sum_ext;
    acc_t                       alu_res;

    function automatic acc_t pick(src_t s);
        acc_t v;
        case (s)
            SRC_ALT:        v = alt_reg;
            SRC_VEL:        v = vel_reg;
            SRC_BIAS:       v = bias_reg;
            SRC_CSUM:       v = csum_reg;
            SRC_PPOS:       v = ppos_reg;
            SRC_ACC:        v = acc_reg;
            SRC_ERR:        v = err_reg;
            SRC_TMP:        v = tmp_reg;
            SRC_MUL:        v = mul_result;
            SRC_DT:         v = acc_t'(dt_reg);
            SRC_ACCEL_DOWN: v = acc_t'(accel_down_reg);
            SRC_BARO:       v = acc_t'(baro_reg);
            SRC_REF:        v = acc_t'(ref_alt_reg);
            SRC_NEG_G:      v = NEG_ONE_G;
            default:        v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_out(acc_t v);
        logic signed [DATA_W-1:0] r;
        if (v > OUT_MAX) begin
            r = OUT_MAX[DATA_W-1:0];
        end else if (v < OUT_MIN) begin
            r = OUT_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        opnd_a = pick(ctl.uw.src_a);
        opnd_b = pick(ctl.uw.src_b);

        // One extra bit holds the exact sum; clamp when it leaves the accumulator range.
        if (ctl.uw.op == UOP_SUB) begin
            sum_ext = {opnd_a[ACCUM_W-1], opnd_a} - {opnd_b[ACCUM_W-1], opnd_b};
        end else begin
            sum_ext = {opnd_a[ACCUM_W-1], opnd_a} + {opnd_b[ACCUM_W-1], opnd_b};
        end
        if (sum_ext[ACCUM_W] != sum_ext[ACCUM_W-1]) begin
            alu_res = sum_ext[ACCUM_W] ? ACC_MIN : ACC_MAX;
        end else begin
            alu_res = sum_ext[ACCUM_W-1:0];
        end

        case (ctl.uw.bsel)
            BSEL_KDT1:      mul_b = kdt1_reg;
            BSEL_KDT2:      mul_b = kdt2_reg;
            BSEL_KDT3:      mul_b = kdt3_reg;
            BSEL_DT:        mul_b = COEF_W'(dt_reg);
            BSEL_GAIN_ALT:  mul_b = gain_alt_reg;
            BSEL_GAIN_VEL:  mul_b = gain_vel_reg;
            BSEL_GAIN_BIAS: mul_b = gain_bias_reg;
            default:        mul_b = '0;
        endcase
        mul_a  = opnd_a;
        mul_sh = ctl.uw.sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_alt_reg  <= GAIN_ALT_RST;
            gain_vel_reg  <= GAIN_VEL_RST;
            gain_bias_reg <= GAIN_BIAS_RST;
            ref_alt_reg   <= '0;
            alt_reg       <= '0;
            vel_reg       <= '0;
            bias_reg      <= '0;
            csum_reg      <= '0;
            ppos_reg      <= '0;
            valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_GAIN_ALT:  gain_alt_reg  <= cfg_data;
                    CFG_GAIN_VEL:  gain_vel_reg  <= cfg_data;
                    CFG_GAIN_BIAS: gain_bias_reg <= cfg_data;
                    CFG_REF_ALT:   ref_alt_reg   <= cfg_data;
                    default: ;
                endcase
            end

            if (ctl.exec) begin
                case (ctl.uw.op)
                    UOP_ADD, UOP_SUB: begin
                        case (ctl.uw.dst)
                            DST_ALT:  alt_reg  <= alu_res;
                            DST_VEL:  vel_reg  <= alu_res;
                            DST_BIAS: bias_reg <= alu_res;
                            DST_CSUM: csum_reg <= alu_res;
                            DST_PPOS: ppos_reg <= alu_res;
                            DST_ACC:  acc_reg  <= alu_res;
                            DST_ERR:  err_reg  <= alu_res;
                            DST_TMP:  tmp_reg  <= alu_res;
                            default: ;
                        endcase
                    end
                    UOP_MOVK: begin
                        case (ctl.uw.dst)
                            DST_KDT1: kdt1_reg <= mul_raw;
                            DST_KDT2: kdt2_reg <= mul_raw;
                            DST_KDT3: kdt3_reg <= mul_raw;
                            default: ;
                        endcase
                    end
                    UOP_CLEAR: begin
                        alt_reg   <= '0;
                        vel_reg   <= '0;
                        bias_reg  <= '0;
                        csum_reg  <= '0;
                        ppos_reg  <= '0;
                        acc_reg   <= '0;
                        valid_reg <= 1'b0;
                    end
                    UOP_OUT: begin
                        out_alt_reg   <= sat_out(alt_reg);
                        out_vel_reg   <= sat_out(vel_reg);
                        out_acc_reg   <= sat_out(acc_reg);
                        out_valid_reg <= valid_reg;
                    end
                    default: ;
                endcase
                if (ctl.uw.set_valid) begin
                    valid_reg <= 1'b1;
                end
            end
        end

        if (ctl.load_in) begin
            accel_down_reg <= s_accel_down;
            baro_reg       <= s_baro_altitude;
            dt_reg         <= s_step_time;
        end
    end

    assign m_altitude_estimate  = out_alt_reg;
    assign m_velocity_estimate  = out_vel_reg;
    assign m_accel_up_corrected = out_acc_reg;
    assign m_estimate_valid     = out_valid_reg;

endmodule
